// File: rtl/core/binary_to_decimal_ascii_digits_macros.svh
// Assertion macros shared by the checker of the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_DIGITS_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_DIGITS_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define B2DA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/b2da_pkg.sv
// Package with the types and constants of the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int DIGITS = 10;
  localparam int BCD_W = 4 * DIGITS;
  localparam int DIG_W = 4;
  localparam int SAT_W = 34;
  localparam int CHAR_W = 6;
  localparam logic [63:0] SAT_VALUE = 64'd9999999999;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/b2da_dabble.sv
// One shift-and-add-three step of the binary to BCD conversion.
module b2da_dabble (
  input  logic [b2da_pkg::BCD_W-1:0] bcd_i,
  input  logic                       bit_i,
  output logic [b2da_pkg::BCD_W-1:0] bcd_o
);
  import b2da_pkg::*;

  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_i[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_i[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd_i[4*d +: 4];
      end
    end
    bcd_o = {adj[BCD_W-2:0], bit_i};
  end

endmodule

// File: rtl/core/binary_to_decimal_ascii_digits.sv
// Top level of the binary to decimal ASCII digit converter.
// One input beat carries an unsigned number; the block sends its decimal digits as ASCII
// characters, most significant first and without leading zeros, one output beat per digit,
// with tlast on the final digit. Values above 9999999999 are clamped to it. The number is
// converted by one shift-and-add-three unit used once per bit, so an item is accepted,
// converted over min(VALUE_WIDTH, 34) bits and then walked through its ten digit positions
// (leading zeros are dropped one per cycle), each digit waiting for the output to be free.
// The input is not ready from acceptance until the last digit is in the output register.
module binary_to_decimal_ascii_digits #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      in_tdata,   // value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata,  // digit_char
  output logic                                  out_tlast   // last
);
  import b2da_pkg::*;

  localparam int SW = (VALUE_WIDTH > SAT_W) ? SAT_W : VALUE_WIDTH;
  localparam int CNT_W = $clog2(SW + 1);

  state_t              state_r, state_nxt;
  logic [SW-1:0]       bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt, bcd_step;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIG_W-1:0]    dig_r, dig_nxt;
  logic                started_r, started_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic [63:0]         val_ext;
  logic [DIG_W-1:0]    top_dig;
  logic                out_free;

  b2da_dabble u_dabble (
    .bcd_i (bcd_r),
    .bit_i (bin_r[SW-1]),
    .bcd_o (bcd_step)
  );

  assign val_ext = 64'(in_tdata[VALUE_WIDTH-1:0]);
  assign top_dig = bcd_r[BCD_W-1 -: DIG_W];
  assign out_free = !out_tvalid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {2'b00, out_char_r};
  assign out_tlast = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    dig_r <= dig_nxt;
    started_r <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    dig_nxt = dig_r;
    started_nxt = started_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (val_ext > SAT_VALUE) begin
            bin_nxt = SAT_VALUE[SW-1:0];
          end else begin
            bin_nxt = val_ext[SW-1:0];
          end
          bcd_nxt = '0;
          cnt_nxt = CNT_W'(SW);
          dig_nxt = DIG_W'(DIGITS);
          started_nxt = 1'b0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_step;
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (top_dig == '0 && !started_r && dig_r != DIG_W'(1)) begin
          bcd_nxt = bcd_r << DIG_W;
          dig_nxt = dig_r - 1'b1;
        end else if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_char_nxt = ASCII_ZERO + CHAR_W'(top_dig);
          out_last_nxt = (dig_r == DIG_W'(1));
          started_nxt = 1'b1;
          bcd_nxt = bcd_r << DIG_W;
          dig_nxt = dig_r - 1'b1;
          if (dig_r == DIG_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/b2da_checker.sv
// Port-level checker of the binary to decimal ASCII converter and its bind.
`include "binary_to_decimal_ascii_digits_macros.svh"

module b2da_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `B2DA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "Output beat changed while stalled.")
  `B2DA_ASSERT_SAME(a_digit_range, out_tvalid, out_tdata[7:6] == 2'b00 && out_tdata[5:0] >= 6'd48 && out_tdata[5:0] <= 6'd57, "Output beat is not a decimal digit.")
  `B2DA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "Input stayed ready after a beat was taken.")
  `B2DA_ASSERT_SAME(a_busy_mid_run, out_tvalid && out_tready && !out_tlast, !in_tready, "Input ready before the last digit was sent.")

endmodule

bind binary_to_decimal_ascii_digits b2da_checker u_b2da_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: sim/tb_binary_to_decimal_ascii_digits.sv
// Testbench for the binary to decimal ASCII digit converter: random-paced stream checks.
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii_digits;
  import b2da_pkg::*;

  localparam int VALUE_W = 32;
  localparam int IN_W = ((VALUE_W + 7) / 8) * 8;
  localparam logic [63:0] VALUE_MASK = (VALUE_W >= 64) ? '1 : ((64'd1 << VALUE_W) - 64'd1);
  localparam int RADIX = 10;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } digit_beat_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [7:0]      out_tdata;
  logic            out_tlast;

  digit_beat_t     pending_digits[$];
  int              mismatch_count = 0;
  int              burst_left = 0;
  bit              sender_no_gaps = 1'b0;
  int              rx_hold_left = 0;
  int              rx_phase = 0;
  logic [15:0]     rx_pattern = '1;

  binary_to_decimal_ascii_digits #(
    .VALUE_WIDTH(VALUE_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic void predict_digits(input logic [IN_W-1:0] raw);
    logic [63:0] num;
    logic [3:0]  rev[DIGITS];
    int          n;
    digit_beat_t beat;
    num = 64'(raw) & VALUE_MASK;
    if (num > SAT_VALUE) num = SAT_VALUE;
    n = 0;
    do begin
      rev[n] = 4'(num % RADIX);
      num = num / RADIX;
      n++;
    end while (num != 0 && n < DIGITS);
    for (int k = 0; k < n; k++) begin
      beat.ch = 8'(ASCII_ZERO + CHAR_W'(rev[n-1-k]));
      beat.last = (k == n - 1);
      pending_digits.push_back(beat);
    end
  endfunction

  function automatic logic [IN_W-1:0] pick_value();
    logic [63:0] lo;
    logic [63:0] hi;
    int          sel;
    int          nd;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      nd = $urandom_range(1, 10);
      lo = 64'd1;
      for (int i = 1; i < nd; i++) lo = lo * RADIX;
      hi = lo * RADIX - 64'd1;
      if (nd == 1) lo = 64'd0;
      if (hi > VALUE_MASK) hi = VALUE_MASK;
      return IN_W'(lo + ({$urandom, $urandom} % (hi - lo + 64'd1)));
    end else if (sel < 7) begin
      return IN_W'({$urandom, $urandom});
    end else if (sel == 7) begin
      nd = $urandom_range(0, 9);
      lo = 64'd1;
      for (int i = 0; i < nd; i++) lo = lo * RADIX;
      return IN_W'(lo + 64'($urandom_range(0, 2)) - 64'd1);
    end else if (sel == 8) begin
      return IN_W'($urandom_range(0, 20));
    end
    return IN_W'(VALUE_MASK - 64'($urandom_range(0, 1000)));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_value(input logic [IN_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = sender_no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    predict_digits(value);
    if (!sender_no_gaps) burst_left--;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_digits.size() != 0);
  endtask

  task automatic test_directed();
    logic [IN_W-1:0] values[$];
    values = '{0, 1, 9, 10, 11, 99, 100, 12345, 999999999, 1000000000, 1000000001,
               1234567890, 2147483647, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
               4000000000, 4294967294, 32'hFFFFFFFF, 999, 1000, 100000};
    foreach (values[i]) send_value(values[i]);
    wait_for_drain();
  endtask

  task automatic test_random_values(input int count);
    for (int i = 0; i < count; i++) send_value(pick_value());
    wait_for_drain();
  endtask

  task automatic test_output_backpressure();
    rx_hold_left = 400;
    sender_no_gaps = 1'b1;
    for (int i = 0; i < 10; i++) send_value(pick_value());
    sender_no_gaps = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_idle_between_runs();
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 10; i++) send_value(pick_value());
      wait_for_drain();
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_phase = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: rx_pattern = '1;
          1: rx_pattern = 16'($urandom);
          2: rx_pattern = 16'($urandom | $urandom);
          default: rx_pattern = 16'($urandom & $urandom) | 16'd1;
        endcase
      end
      rx_phase = rx_phase - 1;
      rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
      out_tready <= rx_pattern[0];
    end
  end

  always @(posedge clk) begin
    digit_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("digit beat with nothing pending", out_tdata, 8'h00);
      end else begin
        want = pending_digits.pop_front();
        if (out_tdata !== want.ch) report_mismatch("digit_char", out_tdata, want.ch);
        if (out_tlast !== want.last) report_mismatch("last", 8'(out_tlast), 8'(want.last));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_values(410);
    test_output_backpressure();
    test_idle_between_runs();
    test_random_values(10);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
